// ===== hw/rtl/s2c_pkg.sv =====
// Shared types, constants and arithmetic helpers for the spherical to
// cartesian converter. No dependencies.
package s2c_pkg;

  // Width of the CORDIC datapath (Q2.30 values with guard bits).
  localparam int CW = 34;

  // CORDIC start value: gain compensation 0.60725293 in Q2.30.
  localparam logic [31:0] GAIN_Q30 = 32'd652032874;
  localparam logic signed [31:0] ONE_Q30 = 32'sd1073741824;
  localparam logic [31:0] QUARTER_HALF = 32'h2000_0000;

  // Division by 360 through a reciprocal: floor(u * RECIP_360 / 2^40).
  localparam logic [31:0] RECIP_360 = 32'd3054198967;
  localparam logic [8:0] DEG_FULL = 9'd360;
  // Offset that makes a signed angle non-negative: 360 * DEG_OFFSET_TURNS.
  localparam logic [32:0] DEG_OFFSET = 33'd2147483880;
  localparam logic [31:0] DEG_OFFSET_TURNS = 32'd5965233;

  // round(2^32 / (2*pi)).
  localparam logic [30:0] INV_TWO_PI = 31'd683565276;

  // Configuration register indexes.
  typedef enum logic [0:0] {
    REG_ANGLE_CONVENTION = 1'b0,
    REG_ANGLES_IN_DEGREES = 1'b1
  } cfg_reg_t;

  typedef struct packed {
    logic signed [31:0] radius;
    logic signed [31:0] azimuth_angle;
    logic signed [31:0] second_angle;
    logic unit_radius;
  } request_t;

  typedef struct packed {
    logic signed [31:0] coord_x;
    logic signed [31:0] coord_y;
    logic signed [31:0] coord_z;
  } result_t;

  // State handed from one CORDIC cell to the next.
  typedef struct packed {
    logic valid;
    logic [1:0] quad;
    logic signed [CW-1:0] x;
    logic signed [CW-1:0] y;
    logic signed [CW-1:0] z;
  } cordic_t;

  // Arctangent of 2^-idx as a fraction of one turn, scaled by 2^32.
  function automatic logic signed [CW-1:0] atan_turn(input int idx);
    logic signed [CW-1:0] val;
    case (idx)
      0: val = 34'sd536870912;
      1: val = 34'sd316933406;
      2: val = 34'sd167458907;
      3: val = 34'sd85004756;
      4: val = 34'sd42667331;
      5: val = 34'sd21354465;
      6: val = 34'sd10679838;
      7: val = 34'sd5340245;
      8: val = 34'sd2670163;
      9: val = 34'sd1335087;
      10: val = 34'sd667544;
      11: val = 34'sd333772;
      12: val = 34'sd166886;
      13: val = 34'sd83443;
      14: val = 34'sd41722;
      15: val = 34'sd20861;
      16: val = 34'sd10430;
      17: val = 34'sd5215;
      18: val = 34'sd2608;
      19: val = 34'sd1304;
      20: val = 34'sd652;
      21: val = 34'sd326;
      22: val = 34'sd163;
      23: val = 34'sd81;
      24: val = 34'sd41;
      25: val = 34'sd20;
      26: val = 34'sd10;
      27: val = 34'sd5;
      28: val = 34'sd3;
      29: val = 34'sd1;
      default: val = '0;
    endcase
    return val;
  endfunction

  // Multiply by a Q2.30 factor, rounding half up, keeping 33 bits.
  // The extra bit holds a full-scale negative radius times minus one.
  function automatic logic signed [32:0] mul_wide(input logic signed [32:0] a,
                                                  input logic signed [31:0] u);
    logic signed [63:0] prod;
    prod = 64'(a) * 64'(u) + 64'sd536870912;
    return prod[62:30];
  endfunction

  // Multiply by a Q2.30 factor, rounding half up, keeping 32 bits.
  function automatic logic signed [31:0] mul_unit(input logic signed [32:0] a,
                                                  input logic signed [31:0] u);
    logic signed [32:0] wide;
    wide = mul_wide(a, u);
    return wide[31:0];
  endfunction

endpackage

// ===== hw/rtl/s2c_phase.sv =====
// Angle to phase converter: degrees or radians in, 32-bit turn fraction out.
// Depends on s2c_pkg.
module s2c_phase #(
  parameter int FRAC_BITS = 16
) (
  input  logic               clk,
  input  logic signed [31:0] angle,
  input  logic               in_degrees,
  output logic [31:0]        phase
);

  localparam int SHIFT = 32 - FRAC_BITS;
  localparam logic [32:0] DEG_OFFSET_W = s2c_pkg::DEG_OFFSET;

  logic [32:0]        u_c;
  logic [64:0]        prod1_c;
  logic signed [62:0] rad_prod;
  logic signed [62:0] rad_sh;
  logic [32:0]        u1;
  logic [24:0]        qe1;
  logic [31:0]        rad1;
  logic [33:0]        est2;
  logic [24:0]        q2_c;
  logic [33:0]        rem2;
  logic [8:0]         ra2;
  logic [32:0]        v2;
  logic [31:0]        qa2;
  logic [31:0]        rad2;
  logic [64:0]        prod3_c;
  logic [24:0]        qe3;
  logic [32:0]        v3;
  logic [31:0]        qa3;
  logic [31:0]        rad3;
  logic [33:0]        est4;
  logic [24:0]        q4_c;

  // First step: offset the angle so it is non-negative and estimate the
  // quotient by 360; in parallel scale a radian angle by 1/(2*pi).
  always_comb begin
    u_c = {angle[31], angle} + DEG_OFFSET_W;
    prod1_c = 65'(u_c) * 65'(s2c_pkg::RECIP_360);
    rad_prod = 63'(angle) * 63'($signed({1'b0, s2c_pkg::INV_TWO_PI}));
    rad_sh = rad_prod >>> FRAC_BITS;
  end

  always_ff @(posedge clk) begin
    u1 <= u_c;
    qe1 <= prod1_c[64:40];
    rad1 <= rad_sh[31:0];
  end

  // Second step: correct the quotient and form the scaled remainder.
  always_comb begin
    est2 = 34'(qe1) * 34'(s2c_pkg::DEG_FULL);
    if (est2 > 34'(u1)) begin
      q2_c = qe1 - 25'd1;
      rem2 = 34'(u1) + 34'(s2c_pkg::DEG_FULL) - est2;
    end else begin
      q2_c = qe1;
      rem2 = 34'(u1) - est2;
    end
    ra2 = rem2[8:0];
  end

  always_ff @(posedge clk) begin
    v2 <= 33'(ra2) << SHIFT;
    qa2 <= 32'(q2_c) - s2c_pkg::DEG_OFFSET_TURNS;
    rad2 <= rad1;
  end

  // Third step: estimate the fraction of a degree turn.
  always_comb begin
    prod3_c = 65'(v2) * 65'(s2c_pkg::RECIP_360);
  end

  always_ff @(posedge clk) begin
    qe3 <= prod3_c[64:40];
    v3 <= v2;
    qa3 <= qa2;
    rad3 <= rad2;
  end

  // Fourth step: correct the fraction, join it to the whole turns, select.
  always_comb begin
    est4 = 34'(qe3) * 34'(s2c_pkg::DEG_FULL);
    if (est4 > 34'(v3)) begin
      q4_c = qe3 - 25'd1;
    end else begin
      q4_c = qe3;
    end
  end

  always_ff @(posedge clk) begin
    if (in_degrees) begin
      phase <= (qa3 << SHIFT) + 32'(q4_c);
    end else begin
      phase <= rad3;
    end
  end

endmodule

// ===== hw/rtl/s2c_cordic_cell.sv =====
// One rotation-mode CORDIC cell with a fixed shift; cells are chained.
// Depends on s2c_pkg.
module s2c_cordic_cell #(
  parameter int STAGE = 0
) (
  input  logic              clk,
  input  logic              rst,
  input  s2c_pkg::cordic_t  prev,
  output s2c_pkg::cordic_t  cur
);

  logic signed [s2c_pkg::CW-1:0] dx;
  logic signed [s2c_pkg::CW-1:0] dy;
  logic signed [s2c_pkg::CW-1:0] angle_step;

  // Shifted cross terms and this cell's arctangent.
  always_comb begin
    dx = prev.y >>> STAGE;
    dy = prev.x >>> STAGE;
    angle_step = s2c_pkg::atan_turn(STAGE);
  end

  // The valid flag is control state and is cleared by reset.
  always_ff @(posedge clk) begin
    if (rst) begin
      cur.valid <= 1'b0;
    end else begin
      cur.valid <= prev.valid;
    end
  end

  // Rotate toward a zero residual angle.
  always_ff @(posedge clk) begin
    cur.quad <= prev.quad;
    if (!prev.z[s2c_pkg::CW-1]) begin
      cur.x <= prev.x - dx;
      cur.y <= prev.y + dy;
      cur.z <= prev.z - angle_step;
    end else begin
      cur.x <= prev.x + dx;
      cur.y <= prev.y - dy;
      cur.z <= prev.z + angle_step;
    end
  end

endmodule

// ===== hw/rtl/spherical_to_cartesian_core.sv =====
// Spherical to cartesian converter, fully pipelined.
// Throughput: one transfer per cycle while busy is low; the chain of CORDIC
// cells sets the depth. Reset clears the pipeline valid flags and loads the
// registers to elevation convention with angles in degrees; busy is a
// registered copy of reset. The receiver cannot stall: each result is
// shown for one cycle with done.
module spherical_to_cartesian_core #(
  parameter int FRAC_BITS = 16,
  parameter int CORDIC_STAGES = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  s2c_pkg::request_t  request,
  output logic               done,
  output s2c_pkg::result_t   result,
  input  logic               cfg_we,
  input  logic               cfg_index,
  input  logic               cfg_data
);

  localparam int RDEPTH = CORDIC_STAGES + 5;
  localparam int LATENCY = CORDIC_STAGES + 7;

  logic                 angle_convention;
  logic                 angles_in_degrees;
  logic                 accept;
  logic [3:0]           ph_valid;
  logic [31:0]          phase_az;
  logic [31:0]          phase_sa;
  logic signed [31:0]   r_pipe [RDEPTH];
  s2c_pkg::cordic_t     az_chain [CORDIC_STAGES+1];
  s2c_pkg::cordic_t     sa_chain [CORDIC_STAGES+1];
  logic signed [31:0]   ca_c, sna_c, c2_c, s2_c;
  logic                 p0_valid;
  logic signed [31:0]   h0, v0, ca0, sna0;
  logic                 p1_valid;
  logic signed [32:0]   rh1;
  logic signed [31:0]   z1, ca1, sna1;

  assign accept = start && !busy;

  // Busy is a registered copy of reset.
  always_ff @(posedge clk) begin
    busy <= rst;
  end

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      angle_convention <= 1'b0;
      angles_in_degrees <= 1'b1;
    end else if (cfg_we) begin
      case (cfg_index)
        s2c_pkg::REG_ANGLE_CONVENTION: angle_convention <= cfg_data;
        s2c_pkg::REG_ANGLES_IN_DEGREES: angles_in_degrees <= cfg_data;
        default: ;
      endcase
    end
  end

  // Angle to phase for both angles.
  s2c_phase #(.FRAC_BITS(FRAC_BITS)) u_phase_az (
    .clk(clk), .angle(request.azimuth_angle), .in_degrees(angles_in_degrees),
    .phase(phase_az)
  );

  s2c_phase #(.FRAC_BITS(FRAC_BITS)) u_phase_sa (
    .clk(clk), .angle(request.second_angle), .in_degrees(angles_in_degrees),
    .phase(phase_sa)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      ph_valid <= '0;
    end else begin
      ph_valid <= {ph_valid[2:0], accept};
    end
  end

  // Radius travels beside the angles until the first product.
  always_ff @(posedge clk) begin
    if (request.unit_radius) begin
      r_pipe[0] <= 32'sd1 <<< FRAC_BITS;
    end else begin
      r_pipe[0] <= request.radius;
    end
    for (int i = 1; i < RDEPTH; i++) begin
      r_pipe[i] <= r_pipe[i-1];
    end
  end

  // Chain entry: quadrant split and residual angle.
  function automatic s2c_pkg::cordic_t cordic_entry(input logic [31:0] ph,
                                                    input logic vld);
    s2c_pkg::cordic_t st;
    logic [31:0] rounded;
    logic [31:0] resid;
    rounded = ph + s2c_pkg::QUARTER_HALF;
    st.valid = vld;
    st.quad = rounded[31:30];
    resid = ph - {rounded[31:30], 30'b0};
    st.x = s2c_pkg::CW'(s2c_pkg::GAIN_Q30);
    st.y = '0;
    st.z = {{(s2c_pkg::CW-32){resid[31]}}, resid};
    return st;
  endfunction

  assign az_chain[0] = cordic_entry(phase_az, ph_valid[3]);
  assign sa_chain[0] = cordic_entry(phase_sa, ph_valid[3]);

  // Two chains of CORDIC cells, one per angle.
  for (genvar g = 0; g < CORDIC_STAGES; g++) begin : g_cells
    s2c_cordic_cell #(.STAGE(g)) u_az_cell (
      .clk(clk), .rst(rst), .prev(az_chain[g]), .cur(az_chain[g+1])
    );
    s2c_cordic_cell #(.STAGE(g)) u_sa_cell (
      .clk(clk), .rst(rst), .prev(sa_chain[g]), .cur(sa_chain[g+1])
    );
  end

  // Clamp to the unit range and rotate by the quadrant.
  function automatic logic signed [31:0] clamp_unit(
      input logic signed [s2c_pkg::CW-1:0] v);
    logic signed [31:0] res;
    if (v > s2c_pkg::CW'(s2c_pkg::ONE_Q30)) begin
      res = s2c_pkg::ONE_Q30;
    end else if (v < -s2c_pkg::CW'(s2c_pkg::ONE_Q30)) begin
      res = -s2c_pkg::ONE_Q30;
    end else begin
      res = v[31:0];
    end
    return res;
  endfunction

  function automatic logic signed [63:0] rotate_quad(input s2c_pkg::cordic_t st);
    logic signed [31:0] cx, cy, c, s;
    cx = clamp_unit(st.x);
    cy = clamp_unit(st.y);
    case (st.quad)
      2'd0: begin c = cx; s = cy; end
      2'd1: begin c = -cy; s = cx; end
      2'd2: begin c = -cx; s = -cy; end
      default: begin c = cy; s = -cx; end
    endcase
    return {c, s};
  endfunction

  always_comb begin
    {ca_c, sna_c} = rotate_quad(az_chain[CORDIC_STAGES]);
    {c2_c, s2_c} = rotate_quad(sa_chain[CORDIC_STAGES]);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      p0_valid <= 1'b0;
    end else begin
      p0_valid <= az_chain[CORDIC_STAGES].valid;
    end
  end

  always_ff @(posedge clk) begin
    ca0 <= ca_c;
    sna0 <= sna_c;
    if (angle_convention) begin
      h0 <= s2_c;
      v0 <= c2_c;
    end else begin
      h0 <= c2_c;
      v0 <= s2_c;
    end
  end

  // First products: horizontal radius and z.
  always_ff @(posedge clk) begin
    if (rst) begin
      p1_valid <= 1'b0;
    end else begin
      p1_valid <= p0_valid;
    end
  end

  always_ff @(posedge clk) begin
    rh1 <= s2c_pkg::mul_wide(33'(r_pipe[RDEPTH-1]), h0);
    z1 <= s2c_pkg::mul_unit(33'(r_pipe[RDEPTH-1]), v0);
    ca1 <= ca0;
    sna1 <= sna0;
  end

  // Second products: x and y, then the result transfer.
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= p1_valid;
    end
  end

  always_ff @(posedge clk) begin
    result.coord_x <= s2c_pkg::mul_unit(rh1, ca1);
    result.coord_y <= s2c_pkg::mul_unit(rh1, sna1);
    result.coord_z <= z1;
  end

  // Every accepted item comes out after the fixed latency.
  a_latency: assert property (@(posedge clk) disable iff (rst)
    accept |-> ##LATENCY done)
    else $error("result transfer missing after fixed latency");

  // Clamped second-angle factors stay within the unit range.
  a_unit_range: assert property (@(posedge clk) disable iff (rst)
    p0_valid |-> (h0 <= s2c_pkg::ONE_Q30) && (h0 >= -s2c_pkg::ONE_Q30)
                 && (v0 <= s2c_pkg::ONE_Q30) && (v0 >= -s2c_pkg::ONE_Q30))
    else $error("trig factor out of unit range");

  // Both CORDIC chains move in step.
  a_chains_aligned: assert property (@(posedge clk) disable iff (rst)
    az_chain[CORDIC_STAGES].valid == sa_chain[CORDIC_STAGES].valid)
    else $error("CORDIC chains out of step");

  // Reset leaves degrees mode and the elevation convention selected.
  a_reset_cfg: assert property (@(posedge clk)
    rst |=> angles_in_degrees && !angle_convention)
    else $error("configuration reset value wrong");

endmodule
